/* hdl/bmhq_pkg.sv */
// bmhq_pkg: shared constants and types for the binary max-heap queue.
// No dependencies.
package bmhq_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActRemove = 2'd1;
  localparam logic [1:0] ActSetTop = 2'd2;

  localparam logic [1:0] StDone  = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef struct packed {
    logic signed [15:0] prio;
    logic [15:0]        tag;
  } entry_t;

  // memory port request from the controller
  typedef struct packed {
    logic        we;
    logic [AddrW-1:0] waddr;
    entry_t      wdata;
    logic [AddrW-1:0] raddr_a;
    logic [AddrW-1:0] raddr_b;
  } mem_req_t;
endpackage

/* hdl/bmhq_ram.sv */
// bmhq_ram: heap store, one write port and two registered read ports.
// Depends on bmhq_pkg.
module bmhq_ram (
  input  logic               clk_i,
  input  bmhq_pkg::mem_req_t req_i,
  output bmhq_pkg::entry_t   rdata_a_o,
  output bmhq_pkg::entry_t   rdata_b_o
);
  bmhq_pkg::entry_t mem [bmhq_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.waddr] <= req_i.wdata;
    rdata_a_o <= mem[req_i.raddr_a];
    rdata_b_o <= mem[req_i.raddr_b];
  end
endmodule

/* hdl/bmhq_ctrl.sv */
// bmhq_ctrl: sequencer for insert, remove-max and set-top with sifts.
// Depends on bmhq_pkg; drives bmhq_ram.
module bmhq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           action_i,
  input  logic signed [15:0]   item_priority_i,
  input  logic [15:0]          item_tag_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [bmhq_pkg::CountW-1:0] count_o,
  output bmhq_pkg::entry_t     top_o,
  output bmhq_pkg::mem_req_t   mem_o,
  input  bmhq_pkg::entry_t     rdata_a_i,
  input  bmhq_pkg::entry_t     rdata_b_i
);
  localparam int unsigned AW = bmhq_pkg::AddrW;
  localparam int unsigned CW = bmhq_pkg::CountW;

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_REPORT
  } state_e;

  state_e state_q;
  logic [CW-1:0] fill_q;
  logic [AW-1:0] idx_q;
  bmhq_pkg::entry_t cur_q;   // entry being sifted, held in a register
  bmhq_pkg::entry_t top_q;   // shadow of the root
  logic [1:0] status_q;
  logic done_q;
  logic load_last_q;         // remove-max: take the last entry from the RAM

  logic [AW+1:0] lidx, ridx;
  logic [AW-1:0] pidx;
  logic l_ok, r_ok, go_l, go_r;

  always_comb begin
    lidx = {1'b0, idx_q, 1'b1};
    ridx = {1'b0, idx_q, 1'b0} + (AW+2)'(2);
    pidx = (idx_q - AW'(1)) >> 1;
    l_ok = (lidx < (AW+2)'(fill_q));
    r_ok = (ridx < (AW+2)'(fill_q));
    go_l = l_ok && (rdata_a_i.prio > cur_q.prio);
    go_r = r_ok && (rdata_b_i.prio > (go_l ? rdata_a_i.prio : cur_q.prio));
  end

  always_comb begin
    mem_o = '0;
    mem_o.raddr_a = lidx[AW-1:0];
    mem_o.raddr_b = ridx[AW-1:0];
    unique case (state_q)
      S_UP_RD: begin
        mem_o.raddr_a = pidx;
        // climbed to the root: place the new entry there
        if (idx_q == '0) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = idx_q;
          mem_o.wdata = cur_q;
        end
      end
      S_UP_CMP: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = idx_q;
        mem_o.wdata = (rdata_a_i.prio < cur_q.prio) ? rdata_a_i : cur_q;
      end
      S_DN_CMP: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = idx_q;
        mem_o.wdata = go_r ? rdata_b_i : (go_l ? rdata_a_i : cur_q);
      end
      default: ;
    endcase
    // remove-max reads the last entry in the idle cycle
    if (state_q == S_IDLE) mem_o.raddr_a = AW'(fill_q - CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      status_q    <= bmhq_pkg::StDone;
      done_q      <= 1'b0;
      idx_q       <= '0;
      cur_q       <= '0;
      top_q       <= '0;
      load_last_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_REPORT);
      unique case (state_q)
        S_IDLE: if (start_i) begin
          if (action_i == bmhq_pkg::ActInsert) begin
            if (fill_q == CW'(bmhq_pkg::Capacity)) begin
              status_q <= bmhq_pkg::StFull;
              state_q  <= S_REPORT;
            end else begin
              status_q <= bmhq_pkg::StDone;
              cur_q    <= '{prio: item_priority_i, tag: item_tag_i};
              idx_q    <= AW'(fill_q);
              fill_q   <= fill_q + CW'(1);
              state_q  <= S_UP_RD;
            end
          end else if (action_i == bmhq_pkg::ActRemove ||
                       action_i == bmhq_pkg::ActSetTop) begin
            if (fill_q == '0) begin
              status_q <= bmhq_pkg::StEmpty;
              state_q  <= S_REPORT;
            end else begin
              status_q <= bmhq_pkg::StDone;
              idx_q    <= '0;
              if (action_i == bmhq_pkg::ActRemove) begin
                fill_q <= fill_q - CW'(1);
                cur_q  <= '0; // taken from RAM next cycle
              end else begin
                cur_q <= '{prio: item_priority_i, tag: top_q.tag};
              end
              load_last_q <= (action_i == bmhq_pkg::ActRemove);
              state_q     <= S_DN_RD;
            end
          end else begin
            status_q <= bmhq_pkg::StDone;
            state_q  <= S_REPORT;
          end
        end
        S_UP_RD: begin
          if (idx_q == '0) begin
            top_q   <= cur_q;
            state_q <= S_REPORT;
          end else state_q <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (rdata_a_i.prio < cur_q.prio) begin
            idx_q   <= pidx;
            state_q <= S_UP_RD;
          end else state_q <= S_REPORT;
        end
        S_DN_RD: begin
          if (load_last_q) begin
            cur_q       <= rdata_a_i;  // last entry read in idle cycle
            load_last_q <= 1'b0;
          end
          state_q <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (idx_q == '0)
            top_q <= go_r ? rdata_b_i : (go_l ? rdata_a_i : cur_q);
          if (go_l || go_r) begin
            idx_q   <= go_r ? ridx[AW-1:0] : lidx[AW-1:0];
            state_q <= S_DN_RD;
          end else state_q <= S_REPORT;
        end
        S_REPORT: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign count_o  = fill_q;
  assign top_o    = top_q;
endmodule

/* hdl/binary_max_heap_queue_top.sv */
// Channel  | ports                                   | handshake
// request  | action_i item_priority_i item_tag_i     | start_i high, busy_o low
// result   | status_o is_empty_o top_* entry_count_o | done_o, one cycle, no stall
// Per request: an insert reads and compares once per level climbed, stopping at the root
// or below a parent that is not lower; remove/set reads and compares once per level sunk;
// refused or unknown requests go straight to report. Worst case: a set-top on a full heap
// sinking six levels, each waiting on a RAM read. done_o rises in idle, busy_o low.
// Reset empties the heap; the store itself is not cleared. Results cannot be held off.
// Top level of the binary max-heap queue; depends on bmhq_pkg, bmhq_ram, bmhq_ctrl.
module binary_max_heap_queue_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         action_i,
  input  logic signed [15:0] item_priority_i,
  input  logic [15:0]        item_tag_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic               is_empty_o,
  output logic signed [15:0] top_priority_o,
  output logic [15:0]        top_tag_o,
  output logic [6:0]         entry_count_o
);
  bmhq_pkg::mem_req_t mem_req;
  bmhq_pkg::entry_t   rd_a, rd_b, top;
  logic [bmhq_pkg::CountW-1:0] cnt;

  bmhq_ram u_ram (.clk_i, .req_i(mem_req), .rdata_a_o(rd_a), .rdata_b_o(rd_b));

  bmhq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .action_i, .item_priority_i, .item_tag_i,
    .busy_o, .done_o, .status_o, .count_o(cnt), .top_o(top),
    .mem_o(mem_req), .rdata_a_i(rd_a), .rdata_b_i(rd_b)
  );

  assign is_empty_o     = (cnt == '0);
  assign top_priority_o = is_empty_o ? 16'sd0 : top.prio;
  assign top_tag_o      = is_empty_o ? 16'd0 : top.tag;
  assign entry_count_o  = 7'(cnt);

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= bmhq_pkg::CountW'(bmhq_pkg::Capacity)) else $error("count over capacity");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without request");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == bmhq_pkg::StFull) |-> $stable(cnt)) else $error("full changed");
endmodule

/* verif/tb_binary_max_heap_queue_top.sv */
// Self-checking testbench for binary_max_heap_queue_top: random and directed requests
// are checked against a behavioural heap model. Depends on bmhq_pkg and the block's RTL.
module tb_binary_max_heap_queue_top;

  typedef struct packed {
    logic [1:0]         act;
    logic signed [15:0] prio;
    logic [15:0]        tag;
  } request_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               empty;
    logic signed [15:0] top_prio;
    logic [15:0]        top_tag;
    logic [6:0]         count;
  } outcome_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [1:0]         action_i = bmhq_pkg::ActInsert;
  logic signed [15:0] item_priority_i = '0;
  logic [15:0]        item_tag_i = '0;
  logic               busy_o, done_o, is_empty_o;
  logic [1:0]         status_o;
  logic signed [15:0] top_priority_o;
  logic [15:0]        top_tag_o;
  logic [6:0]         entry_count_o;

  binary_max_heap_queue_top i_dut (.*);

  request_t         pending_reqs[$];
  outcome_t         expected_tops[$];
  bmhq_pkg::entry_t model_heap[bmhq_pkg::Capacity];
  int       model_fill = 0;
  int       errors = 0;
  int       n_driven = 0;
  int       n_accepted = 0;
  bit       stim_done = 1'b0;
  bit       calm = 1'b0;

  initial forever #4 clk_i = ~clk_i;

  function automatic void enqueue_req(request_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  function automatic void swap_slots(int a, int b);
    bmhq_pkg::entry_t t;
    t = model_heap[a];
    model_heap[a] = model_heap[b];
    model_heap[b] = t;
  endfunction

  function automatic void sink_root();
    int i, nxt, l, r;
    i = 0;
    forever begin
      nxt = i;
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (l < model_fill && model_heap[l].prio > model_heap[nxt].prio) nxt = l;
      if (r < model_fill && model_heap[r].prio > model_heap[nxt].prio) nxt = r;
      if (nxt == i) break;
      swap_slots(i, nxt);
      i = nxt;
    end
  endfunction

  function automatic outcome_t apply_request(request_t q);
    outcome_t o;
    int i;
    o = '0;
    o.status = bmhq_pkg::StDone;
    case (q.act)
      bmhq_pkg::ActInsert: begin
        if (model_fill >= bmhq_pkg::Capacity) o.status = bmhq_pkg::StFull;
        else begin
          model_heap[model_fill] = '{prio: q.prio, tag: q.tag};
          i = model_fill;
          model_fill++;
          while (i > 0 && model_heap[i].prio > model_heap[(i - 1) / 2].prio) begin
            swap_slots(i, (i - 1) / 2);
            i = (i - 1) / 2;
          end
        end
      end
      bmhq_pkg::ActRemove: begin
        if (model_fill == 0) o.status = bmhq_pkg::StEmpty;
        else begin
          model_heap[0] = model_heap[model_fill - 1];
          model_fill--;
          sink_root();
        end
      end
      bmhq_pkg::ActSetTop: begin
        if (model_fill == 0) o.status = bmhq_pkg::StEmpty;
        else begin
          model_heap[0].prio = q.prio;
          sink_root();
        end
      end
      default: ;
    endcase
    o.empty = (model_fill == 0);
    if (model_fill != 0) begin
      o.top_prio = model_heap[0].prio;
      o.top_tag  = model_heap[0].tag;
    end
    o.count = model_fill[6:0];
    return o;
  endfunction

  function automatic request_t rand_req(logic [1:0] act);
    request_t q;
    q.act = act;
    // narrow priority band half the time, so equal priorities are common
    q.prio = ($urandom_range(0, 1) != 0) ? 16'($signed($urandom_range(0, 7)) - 3)
                                         : 16'($urandom);
    q.tag = 16'($urandom);
    return q;
  endfunction

  // driver: change on the falling edge; a request is held until the monitor has
  // counted it as taken (start high, busy low at a rising edge)
  int gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || n_accepted == n_driven)) begin
      if (gap > 0) begin
        gap--;
        start_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
          gap = $urandom_range(1, 9) - 1;
          start_i <= 1'b0;
        end else begin
          action_i        <= pending_reqs[0].act;
          item_priority_i <= pending_reqs[0].prio;
          item_tag_i      <= pending_reqs[0].tag;
          start_i         <= 1'b1;
          n_driven++;
          void'(pending_reqs.pop_front());
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: results are checked first, then a request taken at this edge is predicted
  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && done_o) begin
      got = '{status: status_o, empty: is_empty_o, top_prio: top_priority_o,
              top_tag: top_tag_o, count: entry_count_o};
      if (expected_tops.size() == 0) begin
        $display("%0t: unexpected result exp none got %p", $time, got);
        errors++;
      end else begin
        want = expected_tops.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.empty !== want.empty) begin
          $display("%0t: is_empty exp %0d got %0d", $time, want.empty, got.empty);
          errors++;
        end
        if (got.top_prio !== want.top_prio) begin
          $display("%0t: top_priority exp %0d got %0d", $time, want.top_prio, got.top_prio);
          errors++;
        end
        if (got.top_tag !== want.top_tag) begin
          $display("%0t: top_tag exp %h got %h", $time, want.top_tag, got.top_tag);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, want.count, got.count);
          errors++;
        end
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      expected_tops.insert(expected_tops.size(), apply_request(
        '{act: action_i, prio: item_priority_i, tag: item_tag_i}));
      n_accepted++;
    end
  end

  initial begin
    int n;
    logic [1:0] a;
    // directed: empty refusals, extremes, fill to capacity and beyond, drain
    enqueue_req('{act: bmhq_pkg::ActRemove, prio: 16'sd0, tag: 16'h0});
    enqueue_req('{act: bmhq_pkg::ActSetTop, prio: 16'sd5, tag: 16'h0});
    enqueue_req('{act: 2'd3, prio: 16'sd0, tag: 16'h0});
    enqueue_req('{act: bmhq_pkg::ActInsert, prio: 16'sh8000, tag: 16'hffff});
    enqueue_req('{act: bmhq_pkg::ActInsert, prio: 16'sd32767, tag: 16'h0000});
    enqueue_req('{act: bmhq_pkg::ActInsert, prio: 16'sd32767, tag: 16'h5555});
    enqueue_req('{act: bmhq_pkg::ActSetTop, prio: 16'sh8000, tag: 16'haaaa});
    enqueue_req('{act: 2'd3, prio: -16'sd1, tag: 16'hffff});
    enqueue_req('{act: bmhq_pkg::ActRemove, prio: 16'sd0, tag: 16'h0});
    enqueue_req('{act: bmhq_pkg::ActRemove, prio: 16'sd0, tag: 16'h0});
    enqueue_req('{act: bmhq_pkg::ActRemove, prio: 16'sd0, tag: 16'h0});
    enqueue_req('{act: bmhq_pkg::ActRemove, prio: 16'sd0, tag: 16'h0});
    for (int i = 0; i < bmhq_pkg::Capacity + 2; i++)
      enqueue_req(rand_req(bmhq_pkg::ActInsert));
    for (int i = 0; i < 4; i++) enqueue_req(rand_req(bmhq_pkg::ActSetTop));
    for (int i = 0; i < bmhq_pkg::Capacity + 1; i++)
      enqueue_req(rand_req(bmhq_pkg::ActRemove));
    // random phase: alternating fill and drain bias drives the heap to both ends
    n = 0;
    while (n < 700) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: a = bmhq_pkg::ActInsert;
        4, 5, 6:    a = bmhq_pkg::ActRemove;
        7, 8:       a = bmhq_pkg::ActSetTop;
        default:    a = 2'd3;
      endcase
      if ((n / 150) % 2 == 1 && a == bmhq_pkg::ActInsert) a = bmhq_pkg::ActRemove;
      if ((n / 150) % 2 == 0 && a == bmhq_pkg::ActRemove && $urandom_range(0, 1) != 0)
        a = bmhq_pkg::ActInsert;
      enqueue_req(rand_req(a));
      n++;
    end
    #(8 * 5);
    rst_ni = 1'b1;
    wait (pending_reqs.size() < 120);
    calm = 1'b1;
    wait (pending_reqs.size() == 0 && !start_i);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    wait (expected_tops.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
